FILE: rtl/trpu_pkg.sv
// shared constants and types of the tga rle pixel unpacker
package trpu_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 4096;
   localparam int MAX_HEIGHT_DEFAULT = 4096;

   localparam int BYTE_W      = 8;
   localparam int CFG_W       = 13;
   localparam int CSR_INDEX_W = 3;
   localparam int ARGB_W      = 32;
   localparam int ADDR_W      = 24;
   localparam int REP_W       = 8;
   localparam int PHASE_W     = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_PRESENT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RLE_MODE      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOP_DOWN      = 3'd4;

   // byte phase codes of the packet and pixel state machine
   localparam logic [PHASE_W-1:0] PH_HEADER = 3'd0;
   localparam logic [PHASE_W-1:0] PH_BLUE   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_GREEN  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_RED    = 3'd3;
   localparam logic [PHASE_W-1:0] PH_ALPHA  = 3'd4;

   localparam logic [BYTE_W-1:0] ALPHA_DEFAULT = 8'hff;

   typedef struct packed {
      logic alpha_present;
      logic rle_mode;
      logic top_down;
   } cfg_mode_type;

endpackage

FILE: rtl/tga_rle_pixel_unpacker_core.sv
// Unpacks a 24/32-bit TGA pixel byte stream, raw or run-length coded, into ARGB
// words with frame-buffer address, repeat count and end-of-image flag. One byte
// is taken every clock cycle when the result side does not stall, the per-byte
// state update closing within the state registers. Behind the input register a
// pixel result passes the pixel register of the packet and position state
// machine, then the result register after the address multiply. Runs that
// cross a row end are clipped, excess raw pixels of a packet are dropped, and
// rows are written bottom-up unless top_down is set. Configuration is to be
// written through the csr port while the block is idle; the user is bound to
// this, and the block itself does not enforce it.
module tga_rle_pixel_unpacker_core #(
   parameter int MAX_WIDTH  = trpu_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = trpu_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [trpu_pkg::BYTE_W-1:0]      req_data_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [trpu_pkg::ARGB_W-1:0]      rsp_pixel_argb,
   output logic [trpu_pkg::ADDR_W-1:0]      rsp_pixel_address,
   output logic [trpu_pkg::REP_W-1:0]       rsp_repeat_count,
   output logic                             rsp_image_done,
   input  logic                             csr_wr_en,
   input  logic [trpu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [trpu_pkg::CFG_W-1:0]       csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic [CW-1:0]               cfg_width;
   logic [HW-1:0]               cfg_height;
   trpu_pkg::cfg_mode_type      cfg_mode;

   logic                        pix_valid;
   logic                        pix_stall;
   logic [trpu_pkg::ARGB_W-1:0] pix_argb;
   logic [RW-1:0]               pix_memrow;
   logic [CW-1:0]               pix_column;
   logic [trpu_pkg::REP_W-1:0]  pix_rep;
   logic                        pix_done;

   trpu_cfg #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_cfg (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cfg_width  (cfg_width),
      .cfg_height (cfg_height),
      .cfg_mode   (cfg_mode)
   );

   trpu_decode #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_decode (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .cfg_width     (cfg_width),
      .cfg_height    (cfg_height),
      .cfg_mode      (cfg_mode),
      .pix_valid     (pix_valid),
      .pix_stall     (pix_stall),
      .pix_argb      (pix_argb),
      .pix_memrow    (pix_memrow),
      .pix_column    (pix_column),
      .pix_rep       (pix_rep),
      .pix_done      (pix_done)
   );

   trpu_addr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_addr (
      .clock             (clock),
      .reset             (reset),
      .cfg_width         (cfg_width),
      .pix_valid         (pix_valid),
      .pix_stall         (pix_stall),
      .pix_argb          (pix_argb),
      .pix_memrow        (pix_memrow),
      .pix_column        (pix_column),
      .pix_rep           (pix_rep),
      .pix_done          (pix_done),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_argb    (rsp_pixel_argb),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_repeat_count  (rsp_repeat_count),
      .rsp_image_done    (rsp_image_done)
   );

endmodule

FILE: rtl/trpu_cfg.sv
// configuration registers, holding the clamped image size and the mode bits
module trpu_cfg #(
   parameter int MAX_WIDTH  = trpu_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = trpu_pkg::MAX_HEIGHT_DEFAULT,
   localparam int CW = $clog2(MAX_WIDTH + 1),
   localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [trpu_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [trpu_pkg::CFG_W-1:0]         csr_wdata,
   output logic [CW-1:0]                      cfg_width,
   output logic [HW-1:0]                      cfg_height,
   output trpu_pkg::cfg_mode_type             cfg_mode
);

   logic [CW-1:0]          width_ff, width_in;
   logic [HW-1:0]          height_ff, height_in;
   trpu_pkg::cfg_mode_type mode_ff, mode_in;

   // zero reads as one, oversize saturates
   always_comb begin
      if (csr_wdata == '0) begin
         width_in  = CW'(1);
         height_in = HW'(1);
      end else begin
         width_in  = (32'(csr_wdata) > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(csr_wdata);
         height_in = (32'(csr_wdata) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(csr_wdata);
      end
      mode_in = mode_ff;
      case (csr_index)
         trpu_pkg::CSR_ALPHA_PRESENT: mode_in.alpha_present = csr_wdata[0];
         trpu_pkg::CSR_RLE_MODE:      mode_in.rle_mode      = csr_wdata[0];
         trpu_pkg::CSR_TOP_DOWN:      mode_in.top_down      = csr_wdata[0];
         default: mode_in = mode_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CW'(1);
         height_ff <= HW'(1);
         mode_ff   <= '{alpha_present: 1'b0, rle_mode: 1'b1, top_down: 1'b0};
      end else if (csr_wr_en) begin
         if (csr_index == trpu_pkg::CSR_IMAGE_WIDTH) begin
            width_ff <= width_in;
         end
         if (csr_index == trpu_pkg::CSR_IMAGE_HEIGHT) begin
            height_ff <= height_in;
         end
         mode_ff <= mode_in;
      end
   end

   assign cfg_width  = width_ff;
   assign cfg_height = height_ff;
   assign cfg_mode   = mode_ff;

endmodule

FILE: rtl/trpu_decode.sv
// byte input register, packet and pixel state machine, and the pixel stage register
module trpu_decode #(
   parameter int MAX_WIDTH  = trpu_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = trpu_pkg::MAX_HEIGHT_DEFAULT,
   localparam int CW = $clog2(MAX_WIDTH + 1),
   localparam int HW = $clog2(MAX_HEIGHT + 1),
   localparam int RW = $clog2(MAX_HEIGHT)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [trpu_pkg::BYTE_W-1:0]      req_data_byte,
   input  logic [CW-1:0]                    cfg_width,
   input  logic [HW-1:0]                    cfg_height,
   input  trpu_pkg::cfg_mode_type           cfg_mode,
   output logic                             pix_valid,
   input  logic                             pix_stall,
   output logic [trpu_pkg::ARGB_W-1:0]      pix_argb,
   output logic [RW-1:0]                    pix_memrow,
   output logic [CW-1:0]                    pix_column,
   output logic [trpu_pkg::REP_W-1:0]       pix_rep,
   output logic                             pix_done
);

   localparam int XW = (CW > trpu_pkg::REP_W) ? CW : trpu_pkg::REP_W;
   localparam logic [trpu_pkg::REP_W-1:0] PACKET_MAX = 8'd128;

   typedef struct packed {
      logic [RW-1:0] row;
      logic [CW-1:0] col;
      logic          full;
   } pos_type;

   typedef struct packed {
      pos_type                    pos;
      logic                       fire;
      logic [RW-1:0]              memrow;
      logic [CW-1:0]              col;
      logic [trpu_pkg::REP_W-1:0] rep;
      logic                       done;
   } emit_type;

   function automatic pos_type next_row(pos_type p, logic [HW-1:0] h);
      pos_type     q;
      logic [RW:0] r1;
      r1    = (RW+1)'(p.row) + (RW+1)'(1);
      q.col = '0;
      q.full = 1'b0;
      q.row = (r1 >= (RW+1)'(h)) ? '0 : r1[RW-1:0];
      return q;
   endfunction

   function automatic emit_type emit_px(pos_type p, logic [trpu_pkg::REP_W-1:0] count,
                                        logic [CW-1:0] w, logic [HW-1:0] h, logic top);
      emit_type                   e;
      pos_type                    q;
      logic [CW-1:0]              rem;
      logic [XW-1:0]              rem_x;
      logic [trpu_pkg::REP_W-1:0] rep;
      logic [CW-1:0]              col_n;
      logic [RW:0]                hm1;
      q   = p;
      hm1 = (RW+1)'(h) - (RW+1)'(1);
      // height shrunk below the current row
      if ((RW+1)'(q.row) >= (RW+1)'(h)) begin
         q.row  = '0;
         q.col  = '0;
         q.full = 1'b0;
      end
      e.fire   = 1'b0;
      e.memrow = top ? q.row : (hm1[RW-1:0] - q.row);
      e.col    = q.col;
      e.rep    = '0;
      e.done   = 1'b0;
      rem      = w - q.col;
      rem_x    = XW'(rem);
      // clip the run to what is left of the row
      rep      = (XW'(count) < rem_x) ? count : rem_x[trpu_pkg::REP_W-1:0];
      col_n    = q.col + CW'(rep);
      if (q.full || (q.col >= w)) begin
         q.full = 1'b1;
      end else begin
         e.fire = 1'b1;
         e.rep  = rep;
         e.done = (col_n == w) && ((RW+1)'(q.row) == hm1);
         q.col  = col_n;
         if (col_n == w) begin
            q.full = 1'b1;
         end
      end
      e.pos = q;
      return e;
   endfunction

   logic                           in_v_ff;
   logic [trpu_pkg::BYTE_W-1:0]    in_byte_ff;

   logic [trpu_pkg::PHASE_W-1:0]   phase_ff, phase_in;
   logic [trpu_pkg::REP_W-1:0]     left_ff, left_in;
   logic                           run_ff, run_in;
   logic [trpu_pkg::BYTE_W-1:0]    blue_ff, blue_in;
   logic [trpu_pkg::BYTE_W-1:0]    green_ff, green_in;
   logic [trpu_pkg::BYTE_W-1:0]    red_ff, red_in;
   pos_type                        pos_ff, pos_in;

   logic                           s1_v_ff;
   logic [trpu_pkg::ARGB_W-1:0]    s1_argb_ff;
   logic [RW-1:0]                  s1_memrow_ff;
   logic [CW-1:0]                  s1_col_ff;
   logic [trpu_pkg::REP_W-1:0]     s1_rep_ff;
   logic                           s1_done_ff;

   emit_type                       em;
   logic [trpu_pkg::ARGB_W-1:0]    argb;
   logic                           s1_free;
   logic                           consume;

   assign s1_free   = !s1_v_ff || !pix_stall;
   assign consume   = in_v_ff && s1_free;
   assign req_stall = in_v_ff && !s1_free;

   always_comb begin
      logic                        complete;
      logic [trpu_pkg::BYTE_W-1:0] alpha;
      logic [trpu_pkg::REP_W-1:0]  count;
      logic [trpu_pkg::BYTE_W-1:0] b;
      b        = in_byte_ff;
      phase_in = (phase_ff > trpu_pkg::PH_ALPHA) ? trpu_pkg::PH_HEADER : phase_ff;
      pos_in   = pos_ff;
      left_in  = left_ff;
      run_in   = run_ff;
      blue_in  = blue_ff;
      green_in = green_ff;
      red_in   = red_ff;
      alpha    = trpu_pkg::ALPHA_DEFAULT;
      complete = 1'b0;
      count    = trpu_pkg::REP_W'(1);
      em       = '0;
      case (phase_in)
         trpu_pkg::PH_HEADER: begin
            if (pos_in.full) begin
               pos_in = next_row(pos_in, cfg_height);
            end
            if (cfg_mode.rle_mode) begin
               run_in   = b[7];
               left_in  = {1'b0, b[6:0]} + trpu_pkg::REP_W'(1);
               phase_in = trpu_pkg::PH_BLUE;
            end else begin
               left_in  = '0;
               run_in   = 1'b0;
               blue_in  = b;
               phase_in = trpu_pkg::PH_GREEN;
            end
         end
         trpu_pkg::PH_BLUE: begin
            blue_in  = b;
            phase_in = trpu_pkg::PH_GREEN;
         end
         trpu_pkg::PH_GREEN: begin
            green_in = b;
            phase_in = trpu_pkg::PH_RED;
         end
         trpu_pkg::PH_RED: begin
            red_in = b;
            if (cfg_mode.alpha_present) begin
               phase_in = trpu_pkg::PH_ALPHA;
            end else begin
               complete = 1'b1;
            end
         end
         trpu_pkg::PH_ALPHA: begin
            alpha    = b;
            complete = 1'b1;
         end
         default: phase_in = trpu_pkg::PH_HEADER;
      endcase
      argb = {alpha, red_in, green_in, blue_in};
      if (complete) begin
         if (!cfg_mode.rle_mode) begin
            left_in = '0;
            run_in  = 1'b0;
            if (pos_in.full) begin
               pos_in = next_row(pos_in, cfg_height);
            end
            em     = emit_px(pos_in, count, cfg_width, cfg_height, cfg_mode.top_down);
            pos_in = em.pos;
            if (pos_in.full) begin
               pos_in = next_row(pos_in, cfg_height);
            end
            phase_in = trpu_pkg::PH_HEADER;
         end else begin
            if (run_in) begin
               count   = (left_in != '0) ? left_in : trpu_pkg::REP_W'(1);
               em      = emit_px(pos_in, count, cfg_width, cfg_height, cfg_mode.top_down);
               pos_in  = em.pos;
               left_in = '0;
            end else begin
               em     = emit_px(pos_in, count, cfg_width, cfg_height, cfg_mode.top_down);
               pos_in = em.pos;
               if (left_in != '0) begin
                  left_in = left_in - trpu_pkg::REP_W'(1);
               end
            end
            if (left_in == '0) begin
               if (pos_in.full) begin
                  pos_in = next_row(pos_in, cfg_height);
               end
               run_in   = 1'b0;
               phase_in = trpu_pkg::PH_HEADER;
            end else begin
               phase_in = trpu_pkg::PH_BLUE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (!req_stall) begin
         in_v_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= trpu_pkg::PH_HEADER;
         left_ff  <= '0;
         run_ff   <= 1'b0;
         pos_ff   <= '0;
      end else if (consume) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         run_ff   <= run_in;
         pos_ff   <= pos_in;
      end
      if (consume) begin
         blue_ff  <= blue_in;
         green_ff <= green_in;
         red_ff   <= red_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_free) begin
         s1_v_ff <= consume && em.fire;
      end
      if (consume && em.fire) begin
         s1_argb_ff   <= argb;
         s1_memrow_ff <= em.memrow;
         s1_col_ff    <= em.col;
         s1_rep_ff    <= em.rep;
         s1_done_ff   <= em.done;
      end
   end

   assign pix_valid  = s1_v_ff;
   assign pix_argb   = s1_argb_ff;
   assign pix_memrow = s1_memrow_ff;
   assign pix_column = s1_col_ff;
   assign pix_rep    = s1_rep_ff;
   assign pix_done   = s1_done_ff;

   a_left_range: assert property (@(posedge clock) disable iff (reset)
      left_ff <= PACKET_MAX)
      else $error("packet count beyond a full packet");

   a_rep_in_row: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff |-> (s1_rep_ff != '0) &&
                  ((XW+1)'(s1_col_ff) + (XW+1)'(s1_rep_ff) <= (XW+1)'(cfg_width)))
      else $error("pixel span leaves the row");

   a_done_at_row_end: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && s1_done_ff |->
         ((XW+1)'(s1_col_ff) + (XW+1)'(s1_rep_ff) == (XW+1)'(cfg_width)))
      else $error("image end flagged before the row end");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && pix_stall |=> s1_v_ff && $stable(s1_col_ff) && $stable(s1_argb_ff))
      else $error("pixel stage lost a stalled transaction");

endmodule

FILE: rtl/trpu_addr.sv
// frame-buffer address multiply and the result register
module trpu_addr #(
   parameter int MAX_WIDTH  = trpu_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = trpu_pkg::MAX_HEIGHT_DEFAULT,
   localparam int CW = $clog2(MAX_WIDTH + 1),
   localparam int RW = $clog2(MAX_HEIGHT)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [CW-1:0]                    cfg_width,
   input  logic                             pix_valid,
   output logic                             pix_stall,
   input  logic [trpu_pkg::ARGB_W-1:0]      pix_argb,
   input  logic [RW-1:0]                    pix_memrow,
   input  logic [CW-1:0]                    pix_column,
   input  logic [trpu_pkg::REP_W-1:0]       pix_rep,
   input  logic                             pix_done,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [trpu_pkg::ARGB_W-1:0]      rsp_pixel_argb,
   output logic [trpu_pkg::ADDR_W-1:0]      rsp_pixel_address,
   output logic [trpu_pkg::REP_W-1:0]       rsp_repeat_count,
   output logic                             rsp_image_done
);

   localparam int PW = RW + CW;

   logic                        out_v_ff;
   logic [trpu_pkg::ARGB_W-1:0] argb_ff;
   logic [trpu_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [trpu_pkg::REP_W-1:0]  rep_ff;
   logic                        done_ff;
   logic [PW-1:0]               prod;
   logic [PW:0]                 sum;
   logic                        take;

   assign take      = !out_v_ff || !rsp_stall;
   assign pix_stall = !take;

   assign prod    = PW'(pix_memrow) * PW'(cfg_width);
   assign sum     = (PW+1)'(prod) + (PW+1)'(pix_column);
   assign addr_in = trpu_pkg::ADDR_W'(sum);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (take) begin
         out_v_ff <= pix_valid;
      end
      if (take && pix_valid) begin
         argb_ff <= pix_argb;
         addr_ff <= addr_in;
         rep_ff  <= pix_rep;
         done_ff <= pix_done;
      end
   end

   assign rsp_valid         = out_v_ff;
   assign rsp_pixel_argb    = argb_ff;
   assign rsp_pixel_address = addr_ff;
   assign rsp_repeat_count  = rep_ff;
   assign rsp_image_done    = done_ff;

endmodule
